>>> src/uri_component_splitter_assert.svh
// assertion macros for the uri component splitter
`ifndef URI_COMPONENT_SPLITTER_ASSERT_SVH
`define URI_COMPONENT_SPLITTER_ASSERT_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define UCS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ucs assertion failed");
// antecedent implies consequent in the next cycle
`define UCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ucs assertion failed");
`else
`define UCS_ASSERT_NOW(lbl, ante, cons)
`define UCS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> src/ucs_pkg.sv
// shared types and constants for the uri component splitter
`timescale 1ns / 1ps
package ucs_pkg;

  localparam int MAX_LEN = 4096;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);

  typedef logic [LEN_W-1:0] len_t;

  localparam logic [7:0] CH_PLUS     = 8'h2b;
  localparam logic [7:0] CH_DOT      = 8'h2e;
  localparam logic [7:0] CH_DASH     = 8'h2d;
  localparam logic [7:0] CH_SLASH    = 8'h2f;
  localparam logic [7:0] CH_COLON    = 8'h3a;
  localparam logic [7:0] CH_QUESTION = 8'h3f;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7a;
  localparam logic [7:0] CH_DIGIT_0  = 8'h30;
  localparam logic [7:0] CH_DIGIT_9  = 8'h39;

  typedef struct packed {
    logic [7:0] byte_req;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic has_scheme;
    logic authority_found;
    len_t authority_start;
    len_t host_port_length;
    logic path_found;
    len_t path_start;
    logic query_found;
    len_t query_start;
    logic too_long;
  } out_item_t;

endpackage

>>> src/ucs_scan.sv
// per-byte uri scanner: phase tracking, offset capture and result assembly
`timescale 1ns / 1ps
module ucs_scan import ucs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  output out_item_t result
);

  typedef enum logic [2:0] {
    PH_SCHEME,
    PH_COLON1,
    PH_COLON2,
    PH_AUTH,
    PH_NONE,
    PH_DS1,
    PH_DS2
  } phase_t;

  localparam len_t MAX_LEN_C = LEN_W'(MAX_LEN);

  phase_t phase_r, phase_nxt;
  len_t   byte_count_r, byte_count_nxt;
  logic   scheme_ok_r, scheme_ok_nxt;
  logic   auth_flag_r, auth_flag_nxt;
  len_t   auth_off_r, auth_off_nxt;
  logic   slash_flag_r, slash_flag_nxt;
  len_t   slash_off_r, slash_off_nxt;
  logic   q_flag_r, q_flag_nxt;
  len_t   q_off_r, q_off_nxt;
  logic   ovf_r, ovf_nxt;

  len_t       pos;
  logic [LEN_W:0] pos_inc;
  len_t       pos_cap;
  logic [7:0] c;
  logic       is_lower, is_scheme_ch, is_slash;
  logic       fin_auth;
  len_t       fin_aoff, end_pos;

  assign c            = item.byte_req;
  assign is_lower     = (c >= CH_LOWER_A) && (c <= CH_LOWER_Z);
  assign is_scheme_ch = is_lower || ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9)) ||
                        (c == CH_PLUS) || (c == CH_DOT) || (c == CH_DASH);
  assign is_slash     = (c == CH_SLASH);

  always_comb begin
    byte_count_nxt = byte_count_r;
    ovf_nxt        = ovf_r;
    if (byte_count_r >= MAX_LEN_C) begin
      ovf_nxt = 1'b1;
      pos     = MAX_LEN_C;
    end else begin
      pos            = byte_count_r;
      byte_count_nxt = byte_count_r + len_t'(1);
    end
    pos_inc = {1'b0, pos} + {{LEN_W{1'b0}}, 1'b1};
    pos_cap = (pos_inc > {1'b0, MAX_LEN_C}) ? MAX_LEN_C : pos_inc[LEN_W-1:0];

    phase_nxt      = phase_r;
    scheme_ok_nxt  = scheme_ok_r;
    auth_flag_nxt  = auth_flag_r;
    auth_off_nxt   = auth_off_r;
    slash_flag_nxt = slash_flag_r;
    slash_off_nxt  = slash_off_r;
    q_flag_nxt     = q_flag_r;
    q_off_nxt      = q_off_r;

    case (phase_r)
      PH_SCHEME: begin
        if ((pos == '0) && is_slash) begin
          scheme_ok_nxt = 1'b0;
          phase_nxt     = PH_DS1;
        end else if ((pos != '0) && (c == CH_COLON)) begin
          phase_nxt = PH_COLON1;
        end else if ((pos == '0) ? is_lower : is_scheme_ch) begin
          phase_nxt = PH_SCHEME;
        end else begin
          scheme_ok_nxt = 1'b0;
          phase_nxt     = PH_NONE;
        end
      end
      PH_DS1:    phase_nxt = is_slash ? PH_DS2 : PH_NONE;
      PH_DS2: begin
        if (is_slash) begin
          phase_nxt = PH_NONE;
        end else begin
          phase_nxt     = PH_AUTH;
          auth_flag_nxt = 1'b1;
          auth_off_nxt  = len_t'(2);
        end
      end
      PH_COLON1: phase_nxt = is_slash ? PH_COLON2 : PH_NONE;
      PH_COLON2: begin
        if (is_slash) begin
          phase_nxt     = PH_AUTH;
          auth_flag_nxt = 1'b1;
          auth_off_nxt  = pos_cap;
        end else begin
          phase_nxt = PH_NONE;
        end
      end
      PH_AUTH: begin
        if (is_slash && !slash_flag_r) begin
          slash_flag_nxt = 1'b1;
          slash_off_nxt  = pos;
        end
      end
      default: phase_nxt = phase_r;
    endcase

    if ((c == CH_QUESTION) && !q_flag_r) begin
      q_flag_nxt = 1'b1;
      q_off_nxt  = pos_cap;
    end
  end

  // result from the updated state; "//" at the very end still opens an authority
  always_comb begin
    fin_auth = auth_flag_nxt || (phase_nxt == PH_DS2);
    fin_aoff = (phase_nxt == PH_DS2) ? len_t'(2) : auth_off_nxt;
    end_pos  = slash_flag_nxt ? slash_off_nxt : pos_cap;

    result                  = '0;
    result.authority_found  = fin_auth;
    result.has_scheme       = fin_auth && (fin_aoff != len_t'(2));
    result.path_found       = 1'b1;
    if (fin_auth) begin
      result.authority_start  = fin_aoff;
      result.host_port_length = (end_pos > fin_aoff) ? (end_pos - fin_aoff) : '0;
      result.path_found       = slash_flag_nxt;
      result.path_start       = slash_flag_nxt ? slash_off_nxt : '0;
    end
    result.query_found = q_flag_nxt && (q_off_nxt < pos_cap);
    result.query_start = result.query_found ? q_off_nxt : '0;
    result.too_long    = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last)) begin
      phase_r      <= PH_SCHEME;
      byte_count_r <= '0;
      scheme_ok_r  <= 1'b1;
      auth_flag_r  <= 1'b0;
      auth_off_r   <= '0;
      slash_flag_r <= 1'b0;
      slash_off_r  <= '0;
      q_flag_r     <= 1'b0;
      q_off_r      <= '0;
      ovf_r        <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      scheme_ok_r  <= scheme_ok_nxt;
      auth_flag_r  <= auth_flag_nxt;
      auth_off_r   <= auth_off_nxt;
      slash_flag_r <= slash_flag_nxt;
      slash_off_r  <= slash_off_nxt;
      q_flag_r     <= q_flag_nxt;
      q_off_r      <= q_off_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

endmodule

>>> src/uri_component_splitter.sv
// top level of the uri component splitter: input stage, scanner and result register
//
// usage:
//   in_data carries one uri byte per transaction plus a last flag; a uri is
//   any run of bytes closed by one with last set. out_data carries one result
//   per uri (scheme, authority, host/port length, path and query offsets).
//   both channels use valid/stall: a transaction completes on a clock edge
//   with valid high and stall low.
// throughput: one byte per cycle, back to back, across uris too, unless stalled.
// result path: the result of a uri appears on out_valid after the transaction
//   carrying its last byte passes the input register, then the result register.
// stall: while a result waits in the output register, non-final bytes keep
//   flowing; a final byte waits in the input register until the result is
//   taken, and in_stall rises only then.
// reset: synchronous, active low; clears both registers and returns the
//   scanner to the start of a uri. no clearing pass is needed.
// offsets saturate at MAX_LEN; longer uris raise too_long.
`timescale 1ns / 1ps
module uri_component_splitter import ucs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

`include "uri_component_splitter_assert.svh"

  logic      s1_valid_r;
  in_item_t  s1_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      out_free;
  logic      s1_go;
  out_item_t scan_res;

  assign out_free  = !out_valid_r || !out_stall;
  // a final byte may only move on when the result slot frees up
  assign s1_go     = s1_valid_r && (!s1_r.last || out_free);
  assign in_stall  = s1_valid_r && !s1_go;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  ucs_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_go),
    .item   (s1_r),
    .result (scan_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (s1_go && s1_r.last) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_r <= in_data;
    end
    if (s1_go && s1_r.last) begin
      out_data_r <= scan_res;
    end
  end

  `UCS_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s1_go, s1_valid_r && $stable(s1_r))
  `UCS_ASSERT_NEXT(a_last_gives_result, s1_go && s1_r.last, out_valid_r)
  `UCS_ASSERT_NOW(a_scheme_needs_auth, out_valid_r && out_data_r.has_scheme, out_data_r.authority_found)
  `UCS_ASSERT_NOW(a_no_auth_shape, out_valid_r && !out_data_r.authority_found, out_data_r.path_found && (out_data_r.authority_start == '0))
  `UCS_ASSERT_NOW(a_query_offset, out_valid_r && out_data_r.query_found, out_data_r.query_start != '0)

endmodule
